@@ rtl/wcr_pkg.sv @@
package wcr_pkg;

  localparam int COLUMNS_DEF = 128;
  localparam logic [5:0] HEIGHT_MAX = 6'd63;

  localparam logic [1:0] CMD_DRAW  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  localparam logic [1:0] STYLE_NONE  = 2'd0;
  localparam logic [1:0] STYLE_BRICK = 2'd1;
  localparam logic [1:0] STYLE_LINE  = 2'd2;
  localparam logic [1:0] STYLE_SPARE = 2'd3;

  // Divider sizes: the clip numerator magnitude stays below 2^31.
  localparam int DIV_NW = 32;
  localparam int DIV_DW = 16;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_CLEAR,
    ST_MUL,
    ST_CLIP_GO,
    ST_CDIV,
    ST_SETUP,
    ST_SDIV,
    ST_COL_RD,
    ST_COL_WR,
    ST_RD_DATA,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_item;
    logic clear_frame;
    logic clr_step;
    logic clr_colours;
    logic read_capture;
    logic mul;
    logic cdiv_start;
    logic clip_apply;
    logic setup;
    logic sdiv_start;
    logic sdiv_latch;
    logic col_write;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       span_reject;
    logic       need_clip;
    logic       loop_ok;
    logic       dx_zero;
    logic       div_done;
    logic       col_last;
    logic       clr_last;
    logic       out_free;
  } dp_status_t;

endpackage

@@ rtl/wcr_in_if.sv @@
interface wcr_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic signed [15:0] x_left;
  logic [14:0]       h_left;
  logic signed [15:0] x_right;
  logic [14:0]       h_right;
  logic signed [15:0] x_middle;
  logic [7:0]        wall_colour;
  logic [1:0]        left_edge;
  logic [1:0]        right_edge;
  logic [7:0]        window_left;
  logic [7:0]        window_right;
  logic [6:0]        read_column;

  modport source (output valid, cmd, x_left, h_left, x_right, h_right, x_middle,
                  wall_colour, left_edge, right_edge, window_left, window_right,
                  read_column, input ready);
  modport sink (input valid, cmd, x_left, h_left, x_right, h_right, x_middle,
                wall_colour, left_edge, right_edge, window_left, window_right,
                read_column, output ready);
endinterface

@@ rtl/wcr_out_if.sv @@
interface wcr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] columns_drawn;
  logic       any_visible;
  logic [7:0] filled_total;
  logic [5:0] column_height;
  logic [7:0] column_upper;
  logic [7:0] column_lower;

  modport source (output valid, columns_drawn, any_visible, filled_total, column_height,
                  column_upper, column_lower, input ready);
  modport sink (input valid, columns_drawn, any_visible, filled_total, column_height,
                column_upper, column_lower, output ready);
endinterface

@@ rtl/wcr_ram.sv @@
module wcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/wcr_div.sv @@
// Restoring divider, one quotient bit per cycle.
module wcr_div #(
  parameter int NW = wcr_pkg::DIV_NW,
  parameter int DW = wcr_pkg::DIV_DW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient,
  output logic [DW-1:0] remainder
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dvs_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;

  always_comb begin
    shifted  = {rem_r, quo_r[NW-1]};
    diff     = shifted - {1'b0, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = CW'(NW);
    end else if (cnt_r != '0) begin
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = diff[DW-1:0];
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DW-1:0];
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

@@ rtl/wcr_ctrl.sv @@
module wcr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  wcr_pkg::dp_status_t   status,
  output wcr_pkg::ctrl_cmd_t    cmd
);

  wcr_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wcr_pkg::ST_INIT: begin
        if (status.clr_last) state_nxt = wcr_pkg::ST_IDLE;
      end
      wcr_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = wcr_pkg::ST_DECODE;
      end
      wcr_pkg::ST_DECODE: begin
        case (status.cmd)
          wcr_pkg::CMD_DRAW: begin
            if (status.span_reject) state_nxt = wcr_pkg::ST_FINISH;
            else if (status.need_clip) state_nxt = wcr_pkg::ST_MUL;
            else state_nxt = wcr_pkg::ST_SETUP;
          end
          wcr_pkg::CMD_READ:  state_nxt = wcr_pkg::ST_RD_DATA;
          wcr_pkg::CMD_CLEAR: state_nxt = wcr_pkg::ST_CLEAR;
          default:            state_nxt = wcr_pkg::ST_FINISH;
        endcase
      end
      wcr_pkg::ST_CLEAR: begin
        if (status.clr_last) state_nxt = wcr_pkg::ST_FINISH;
      end
      wcr_pkg::ST_MUL:     state_nxt = wcr_pkg::ST_CLIP_GO;
      wcr_pkg::ST_CLIP_GO: state_nxt = wcr_pkg::ST_CDIV;
      wcr_pkg::ST_CDIV: begin
        if (status.div_done) state_nxt = wcr_pkg::ST_SETUP;
      end
      wcr_pkg::ST_SETUP: begin
        if (!status.loop_ok) state_nxt = wcr_pkg::ST_FINISH;
        else if (status.dx_zero) state_nxt = wcr_pkg::ST_COL_RD;
        else state_nxt = wcr_pkg::ST_SDIV;
      end
      wcr_pkg::ST_SDIV: begin
        if (status.div_done) state_nxt = wcr_pkg::ST_COL_RD;
      end
      wcr_pkg::ST_COL_RD: state_nxt = wcr_pkg::ST_COL_WR;
      wcr_pkg::ST_COL_WR: begin
        state_nxt = status.col_last ? wcr_pkg::ST_FINISH : wcr_pkg::ST_COL_RD;
      end
      wcr_pkg::ST_RD_DATA: state_nxt = wcr_pkg::ST_FINISH;
      wcr_pkg::ST_FINISH: begin
        if (status.out_free) state_nxt = wcr_pkg::ST_IDLE;
      end
      default: state_nxt = wcr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      wcr_pkg::ST_INIT: begin
        cmd.clr_step    = 1'b1;
        cmd.clr_colours = 1'b1;
      end
      wcr_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      wcr_pkg::ST_DECODE: begin
        cmd.clear_frame = (status.cmd == wcr_pkg::CMD_CLEAR);
      end
      wcr_pkg::ST_CLEAR:   cmd.clr_step = 1'b1;
      wcr_pkg::ST_MUL:     cmd.mul = 1'b1;
      wcr_pkg::ST_CLIP_GO: cmd.cdiv_start = 1'b1;
      wcr_pkg::ST_CDIV:    cmd.clip_apply = status.div_done;
      wcr_pkg::ST_SETUP: begin
        cmd.setup      = 1'b1;
        cmd.sdiv_start = status.loop_ok && !status.dx_zero;
      end
      wcr_pkg::ST_SDIV:    cmd.sdiv_latch = status.div_done;
      wcr_pkg::ST_COL_WR:  cmd.col_write = 1'b1;
      wcr_pkg::ST_RD_DATA: cmd.read_capture = 1'b1;
      wcr_pkg::ST_FINISH:  cmd.finish = status.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wcr_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/wcr_datapath.sv @@
module wcr_datapath #(
  parameter int COLUMNS = wcr_pkg::COLUMNS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  wcr_in_if.sink              in_chan,
  wcr_out_if.source           out_chan,
  input  wcr_pkg::ctrl_cmd_t  cmd,
  output wcr_pkg::dp_status_t status
);

  localparam int AW = $clog2(COLUMNS);
  localparam int XW = $clog2(COLUMNS + 1);
  localparam logic [9:0] COLS_W = 10'(COLUMNS);
  localparam logic [AW-1:0] LAST_COL = AW'(COLUMNS - 1);

  // Heights and the two colours live in separate memories so that a frame
  // clear can zero the heights alone.
  logic [5:0]    h_wdata, h_rdata;
  logic [15:0]   c_wdata, c_rdata;
  logic          h_we, c_we, col_we;
  logic [AW-1:0] ram_addr;
  logic [AW-1:0] clr_r;
  logic          clr_end;

  logic [1:0]         cmd_r;
  logic signed [15:0] x1_r, x2_r, xm_r;
  logic [14:0]        w1_r, w2_r;
  logic [7:0]         colour_r, wl_r, wr_r;
  logic [1:0]         el_r, er_r;
  logic [6:0]         rc_r;

  logic [31:0] prod_r;
  logic        neg_r;
  logic [14:0] dx_r, q_r, r_r, w_r;
  logic        wdown_r;
  logic signed [15:0] e_r;
  logic [XW-1:0] x_r;

  logic [7:0] drawn_r, filled_r;
  logic [5:0] rd_h_r;
  logic [7:0] rd_u_r, rd_l_r;

  logic        out_valid_r;
  logic [7:0]  out_drawn_r, out_filled_r, out_u_r, out_l_r;
  logic        out_any_r;
  logic [5:0]  out_h_r;

  logic signed [16:0] x1_s, x2_s, wl_s, end_s, x_s, xm_s;
  logic [9:0]  end10, xn10;
  logic [16:0] clip_a, clip_den;
  logic signed [15:0] hdiff;
  logic [14:0] hmag, dw;
  logic [31:0] div_nd;
  logic [15:0] div_ds;
  logic [31:0] div_q;
  logic [15:0] div_r;
  logic        div_done;
  logic [8:0]  rc_ext;
  logic [AW-1:0] rc_addr, x_addr;
  logic        rd_ok;
  logic [5:0]  st_h;
  logic        hit;
  logic [5:0]  h_sat;
  logic [7:0]  up_c, lo_c;
  logic signed [15:0] e_sub;
  logic [15:0] w_inc;

  always_comb begin
    x1_s   = 17'(x1_r);
    x2_s   = 17'(x2_r);
    xm_s   = 17'(xm_r);
    wl_s   = $signed({9'b0, wl_r});
    end10  = ({2'b0, wr_r} < COLS_W) ? {2'b0, wr_r} : COLS_W;
    end_s  = $signed({7'b0, end10});
    x_s    = $signed({{(17 - XW){1'b0}}, x_r});
    xn10   = {{(10 - XW){1'b0}}, x_r} + 10'd1;
    clip_a = 17'(wl_s - x1_s);
    clip_den = 17'(x2_s - x1_s);
    hdiff  = $signed({1'b0, w2_r}) - $signed({1'b0, w1_r});
    hmag   = hdiff[15] ? 15'(-hdiff) : hdiff[14:0];
    dw     = (w1_r < w2_r) ? (w2_r - w1_r) : (w1_r - w2_r);
    rc_ext = {2'b0, rc_r};
    rc_addr = rc_ext[AW-1:0];
    x_addr = x_r[AW-1:0];
    rd_ok  = ({3'b0, rc_r} < COLS_W);
    clr_end = (clr_r == LAST_COL);
  end

  // The clip divides the interpolation product; the setup divides the
  // height slope into whole and fractional steps per column.
  assign div_nd = cmd.cdiv_start ? prod_r : {17'b0, dw};
  assign div_ds = cmd.cdiv_start ? clip_den[15:0] : {1'b0, 15'(x2_r - x1_r)};

  wcr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.cdiv_start || cmd.sdiv_start),
    .dividend  (div_nd),
    .divisor   (div_ds),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign ram_addr = cmd.clr_step ? clr_r :
                    ((cmd_r == wcr_pkg::CMD_READ) ? rc_addr : x_addr);

  always_comb begin
    st_h  = h_rdata;
    hit   = ({9'b0, st_h} < w_r);
    h_sat = (w_r > 15'(wcr_pkg::HEIGHT_MAX)) ? wcr_pkg::HEIGHT_MAX : w_r[5:0];
    if (x_s == x1_s && el_r == wcr_pkg::STYLE_BRICK) begin
      up_c = 8'd0;     lo_c = colour_r;
    end else if (x_s == x1_s && el_r == wcr_pkg::STYLE_LINE) begin
      up_c = 8'd0;     lo_c = 8'd0;
    end else if (x_s == x2_s && er_r == wcr_pkg::STYLE_LINE) begin
      up_c = 8'd0;     lo_c = 8'd0;
    end else if (x_s == xm_s) begin
      up_c = colour_r; lo_c = 8'd0;
    end else begin
      up_c = colour_r; lo_c = colour_r;
    end
    col_we  = cmd.col_write && hit;
    h_we    = cmd.clr_step || col_we;
    c_we    = (cmd.clr_step && cmd.clr_colours) || col_we;
    h_wdata = cmd.clr_step ? 6'd0 : h_sat;
    c_wdata = cmd.clr_step ? 16'd0 : {up_c, lo_c};
    e_sub     = e_r - $signed({1'b0, r_r});
    w_inc     = e_sub[15] ? ({1'b0, q_r} + 16'd1) : {1'b0, q_r};
  end

  wcr_ram #(.WIDTH(6), .DEPTH(COLUMNS)) u_hram (
    .clk   (clk),
    .we    (h_we),
    .addr  (ram_addr),
    .wdata (h_wdata),
    .rdata (h_rdata)
  );

  wcr_ram #(.WIDTH(16), .DEPTH(COLUMNS)) u_cram (
    .clk   (clk),
    .we    (c_we),
    .addr  (ram_addr),
    .wdata (c_wdata),
    .rdata (c_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cmd_r    <= in_chan.cmd;
      x1_r     <= in_chan.x_left;
      w1_r     <= in_chan.h_left;
      x2_r     <= in_chan.x_right;
      w2_r     <= in_chan.h_right;
      xm_r     <= in_chan.x_middle;
      colour_r <= in_chan.wall_colour;
      el_r     <= in_chan.left_edge;
      er_r     <= in_chan.right_edge;
      wl_r     <= in_chan.window_left;
      wr_r     <= in_chan.window_right;
      rc_r     <= in_chan.read_column;
      drawn_r  <= '0;
      rd_h_r   <= '0;
      rd_u_r   <= '0;
      rd_l_r   <= '0;
    end
    if (cmd.mul) begin
      prod_r <= 32'(clip_a * {2'b0, hmag});
      neg_r  <= hdiff[15];
    end
    if (cmd.clip_apply) begin
      w1_r <= neg_r ? (w1_r - div_q[14:0]) : (w1_r + div_q[14:0]);
      x1_r <= {8'b0, wl_r};
      el_r <= wcr_pkg::STYLE_NONE;
    end
    if (cmd.setup) begin
      dx_r    <= 15'(x2_r - x1_r);
      e_r     <= {2'b0, 14'(15'(x2_r - x1_r) >> 1)};
      w_r     <= w1_r;
      wdown_r <= !(w1_r < w2_r);
      x_r     <= XW'(x1_r);
      q_r     <= '0;
      r_r     <= '0;
    end
    if (cmd.sdiv_latch) begin
      q_r <= div_q[14:0];
      r_r <= div_r[14:0];
    end
    if (cmd.col_write) begin
      if (hit && drawn_r != 8'hFF) drawn_r <= drawn_r + 8'd1;
      x_r <= x_r + 1'b1;
      e_r <= e_sub[15] ? (e_sub + $signed({1'b0, dx_r})) : e_sub;
      w_r <= wdown_r ? (w_r - w_inc[14:0]) : (w_r + w_inc[14:0]);
    end
    if (cmd.read_capture && rd_ok) begin
      rd_h_r <= h_rdata;
      rd_u_r <= c_rdata[15:8];
      rd_l_r <= c_rdata[7:0];
    end
    if (cmd.finish) begin
      out_drawn_r  <= drawn_r;
      out_any_r    <= (drawn_r != 8'd0);
      out_filled_r <= filled_r;
      out_h_r      <= rd_h_r;
      out_u_r      <= rd_u_r;
      out_l_r      <= rd_l_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r    <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear_frame) begin
        filled_r <= '0;
      end else if (col_we && st_h == 6'd0 && filled_r != 8'hFF) begin
        filled_r <= filled_r + 8'd1;
      end
      if (cmd.clr_step) clr_r <= clr_end ? '0 : clr_r + 1'b1;
      if (cmd.finish) out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    status.cmd         = cmd_r;
    status.span_reject = (x2_s < x1_s) || (x1_s < wl_s && x2_s < wl_s);
    status.need_clip   = (x1_s < wl_s);
    status.loop_ok     = (x1_s < end_s);
    status.dx_zero     = (x2_r == x1_r);
    status.div_done    = div_done;
    status.col_last    = (x_s == x2_s) || (xn10 >= end10);
    status.clr_last    = clr_end;
    status.out_free    = !out_valid_r || out_chan.ready;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.columns_drawn = out_drawn_r;
  assign out_chan.any_visible   = out_any_r;
  assign out_chan.filled_total  = out_filled_r;
  assign out_chan.column_height = out_h_r;
  assign out_chan.column_upper  = out_u_r;
  assign out_chan.column_lower  = out_l_r;

endmodule

@@ rtl/wall_column_rasterizer_unit.sv @@
// Wall span rasterizer over a frame of COLUMNS columns with a per-column depth
// store. One command is taken at a time and answers with exactly one result;
// the next command may be accepted while that result still waits on the output.
// A clear zeroes the height memory one column per cycle. A draw that is not
// rejected outright first clips the left end when needed, with a multiply and a
// division, then divides the slope when the span is wider than one column, and
// then visits each column. A new result waits until the previous one is taken.
// The two divisions run on one shared bit-serial divider at one bit per cycle,
// and each column takes a read and then a write of the single-port column
// memories. After reset the block zeroes heights and colours in every column
// before it accepts its first command.
module wall_column_rasterizer_unit #(
  parameter int COLUMNS = wcr_pkg::COLUMNS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  wcr_in_if.sink    in_chan,
  wcr_out_if.source out_chan
);

  wcr_pkg::ctrl_cmd_t  cmd;
  wcr_pkg::dp_status_t status;
  logic                in_ready;

  assign in_chan.ready = in_ready;

  wcr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  wcr_datapath #(.COLUMNS(COLUMNS)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

@@ rtl/wcr_checker.sv @@
module wcr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] columns_drawn,
  input logic       any_visible,
  input logic [5:0] column_height,
  input logic [7:0] column_upper,
  input logic [7:0] column_lower
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(columns_drawn) && $stable(column_height))
    else $error("stalled result beat changed");

  // Commands are worked one at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second command taken while one is in work");

  // Draw and read fields never appear together in one result.
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (any_visible == (columns_drawn != 8'd0)) &&
                  !(any_visible && (column_height != 6'd0 || column_upper != 8'd0 ||
                                    column_lower != 8'd0)))
    else $error("result fields inconsistent");

endmodule

bind wall_column_rasterizer_unit wcr_checker u_wcr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .columns_drawn (out_chan.columns_drawn),
  .any_visible   (out_chan.any_visible),
  .column_height (out_chan.column_height),
  .column_upper  (out_chan.column_upper),
  .column_lower  (out_chan.column_lower)
);

@@ tb/sv/wcr_tb_ifs.sv @@
`timescale 1ns / 1ps
package wcr_tb_pkg;
  // One command beat and one result beat as the testbench carries them.
  typedef struct {
    logic [1:0]         cmd;
    logic signed [15:0] x_left;
    logic [14:0]        h_left;
    logic signed [15:0] x_right;
    logic [14:0]        h_right;
    logic signed [15:0] x_middle;
    logic [7:0]         wall_colour;
    logic [1:0]         left_edge;
    logic [1:0]         right_edge;
    logic [7:0]         window_left;
    logic [7:0]         window_right;
    logic [6:0]         read_column;
  } span_cmd_t;

  typedef struct {
    logic [7:0] columns_drawn;
    logic       any_visible;
    logic [7:0] filled_total;
    logic [5:0] column_height;
    logic [7:0] column_upper;
    logic [7:0] column_lower;
  } span_res_t;
endpackage

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
module tb;

  localparam int NCOL = 128;
  localparam int LIMIT = 5000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   errors = 0;
  int   cycles = 0;
  int   n_draw = 0, n_read = 0, n_clear = 0, n_clip = 0;
  bit   sending_done = 1'b0;
  bit   hold_off = 1'b0;

  always #1 clk = ~clk;

  wcr_in_if  in_chan ();
  wcr_out_if out_chan ();

  wall_column_rasterizer_unit dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source)
  );

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("MISMATCH %s: got %0d want %0d", what, got, want);
  endtask

  class frame_scoreboard;
    logic [5:0] heights[NCOL];
    logic [7:0] uppers[NCOL];
    logic [7:0] lowers[NCOL];
    logic [7:0] filled;
    wcr_tb_pkg::span_res_t pending[$];

    function new();
      foreach (heights[i]) begin
        heights[i] = '0; uppers[i] = '0; lowers[i] = '0;
      end
      filled = '0;
    endfunction

    function int draw(wcr_tb_pkg::span_cmd_t c);
      int x1, w1, x2, w2, xm, wl, wr, dx, werr, w, dw, wstep, x, stop, drawn;
      logic [1:0] el;
      longint num;
      logic [7:0] up, lo;
      x1 = c.x_left; w1 = c.h_left; x2 = c.x_right; w2 = c.h_right;
      xm = c.x_middle; wl = c.window_left; wr = c.window_right;
      el = c.left_edge;
      drawn = 0;
      if (x2 < x1) return 0;
      if (x1 < wl) begin
        if (x2 < wl) return 0;
        el = wcr_pkg::STYLE_NONE;
        num = longint'(wl - x1) * longint'(w2 - w1);
        w1 += int'(num / longint'(x2 - x1));
        x1 = wl;
      end
      dx = x2 - x1;
      werr = dx / 2;
      w = w1;
      if (w1 < w2) begin dw = w2 - w1; wstep = 1; end
      else begin dw = w1 - w2; wstep = -1; end
      stop = wr < NCOL ? wr : NCOL;
      for (x = x1; x < stop; x++) begin
        if (int'(heights[x]) < w) begin
          if (drawn < 255) drawn++;
          if (heights[x] == 0 && filled < 255) filled++;
          heights[x] = w > 63 ? 6'd63 : w[5:0];
          if (x == x1 && el == wcr_pkg::STYLE_BRICK) begin
            up = '0; lo = c.wall_colour;
          end else if (x == x1 && el == wcr_pkg::STYLE_LINE) begin
            up = '0; lo = '0;
          end else if (x == x2 && c.right_edge == wcr_pkg::STYLE_LINE) begin
            up = '0; lo = '0;
          end else if (x == xm) begin
            up = c.wall_colour; lo = '0;
          end else begin
            up = c.wall_colour; lo = c.wall_colour;
          end
          uppers[x] = up; lowers[x] = lo;
        end
        if (x == x2) break;
        werr -= dw;
        while (werr < 0) begin w += wstep; werr += dx; end
      end
      return drawn;
    endfunction

    function void note_command(wcr_tb_pkg::span_cmd_t c);
      wcr_tb_pkg::span_res_t r;
      int d;
      r = '{default: '0};
      if (c.cmd == wcr_pkg::CMD_DRAW) begin
        d = draw(c);
        r.columns_drawn = d[7:0];
        r.any_visible = d != 0;
      end else if (c.cmd == wcr_pkg::CMD_READ) begin
        r.column_height = heights[c.read_column];
        r.column_upper = uppers[c.read_column];
        r.column_lower = lowers[c.read_column];
      end else if (c.cmd == wcr_pkg::CMD_CLEAR) begin
        foreach (heights[i]) heights[i] = '0;
        filled = '0;
      end
      r.filled_total = filled;
      pending.push_back(r);
    endfunction

    task check_result(wcr_tb_pkg::span_res_t g);
      wcr_tb_pkg::span_res_t e;
      if (pending.size() == 0) begin
        report("unexpected result", 1, 0);
        return;
      end
      e = pending.pop_front();
      if (g.columns_drawn !== e.columns_drawn)
        report("columns_drawn", g.columns_drawn, e.columns_drawn);
      if (g.any_visible !== e.any_visible) report("any_visible", g.any_visible, e.any_visible);
      if (g.filled_total !== e.filled_total)
        report("filled_total", g.filled_total, e.filled_total);
      if (g.column_height !== e.column_height)
        report("column_height", g.column_height, e.column_height);
      if (g.column_upper !== e.column_upper)
        report("column_upper", g.column_upper, e.column_upper);
      if (g.column_lower !== e.column_lower)
        report("column_lower", g.column_lower, e.column_lower);
    endtask
  endclass

  frame_scoreboard       board = new();
  wcr_tb_pkg::span_cmd_t stim[$];

  initial begin
    in_chan.valid = 1'b0; in_chan.cmd = '0; in_chan.x_left = '0; in_chan.h_left = '0;
    in_chan.x_right = '0; in_chan.h_right = '0; in_chan.x_middle = '0;
    in_chan.wall_colour = '0; in_chan.left_edge = '0; in_chan.right_edge = '0;
    in_chan.window_left = '0; in_chan.window_right = '0; in_chan.read_column = '0;
    out_chan.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // Accepted beats on both channels are observed at the rising edge.
  always @(posedge clk) begin
    wcr_tb_pkg::span_res_t g;
    wcr_tb_pkg::span_cmd_t c;
    if (rst_n && in_chan.valid && in_chan.ready) begin
      c.cmd = in_chan.cmd; c.x_left = in_chan.x_left; c.h_left = in_chan.h_left;
      c.x_right = in_chan.x_right; c.h_right = in_chan.h_right;
      c.x_middle = in_chan.x_middle; c.wall_colour = in_chan.wall_colour;
      c.left_edge = in_chan.left_edge; c.right_edge = in_chan.right_edge;
      c.window_left = in_chan.window_left; c.window_right = in_chan.window_right;
      c.read_column = in_chan.read_column;
      board.note_command(c);
    end
    if (rst_n && out_chan.valid && out_chan.ready) begin
      g.columns_drawn = out_chan.columns_drawn; g.any_visible = out_chan.any_visible;
      g.filled_total = out_chan.filled_total; g.column_height = out_chan.column_height;
      g.column_upper = out_chan.column_upper; g.column_lower = out_chan.column_lower;
      board.check_result(g);
    end
  end

  // Receiver: its own stall pattern, a quiet stretch, and one long hold-off.
  initial begin
    int mode;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) out_chan.ready <= 1'b0;
      else begin
        mode = (cycles / 3000) % 3;
        if (mode == 0) out_chan.ready <= 1'b1;
        else if (mode == 1) out_chan.ready <= ($urandom_range(0, 3) != 0);
        else out_chan.ready <= ($urandom_range(0, 9) < 3);
      end
    end
  end

  initial begin
    int k;
    @(posedge rst_n);
    wait (n_draw + n_read + n_clear > 300);
    hold_off = 1'b1;
    for (k = 0; k < 600; k++) @(posedge clk);
    hold_off = 1'b0;
  end

  function automatic wcr_tb_pkg::span_cmd_t make_draw(int xl, int hl, int xr, int hr,
                                                      int xm, int col, int el, int er,
                                                      int wl, int wr);
    wcr_tb_pkg::span_cmd_t c;
    c = '{default: '0};
    c.cmd = wcr_pkg::CMD_DRAW; c.x_left = 16'(xl); c.h_left = 15'(hl);
    c.x_right = 16'(xr); c.h_right = 15'(hr); c.x_middle = 16'(xm);
    c.wall_colour = 8'(col); c.left_edge = 2'(el); c.right_edge = 2'(er);
    c.window_left = 8'(wl); c.window_right = 8'(wr); c.read_column = 7'($urandom);
    return c;
  endfunction

  function automatic wcr_tb_pkg::span_cmd_t make_other(logic [1:0] op, int colm);
    wcr_tb_pkg::span_cmd_t c;
    c = make_draw($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom);
    c.cmd = op; c.read_column = 7'(colm);
    return c;
  endfunction

  function automatic wcr_tb_pkg::span_cmd_t random_command();
    wcr_tb_pkg::span_cmd_t c;
    int r, xl, wl;
    r = $urandom_range(0, 99);
    if (r < 15) return make_other(wcr_pkg::CMD_READ, $urandom_range(0, 127));
    if (r < 18) return make_other(wcr_pkg::CMD_CLEAR, 0);
    if (r < 19) return make_other(wcr_pkg::CMD_SPARE, 0);
    if (r < 24) begin
      // Raw noise over the whole field ranges.
      c = make_draw($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom);
      return c;
    end
    // Well-formed span (reversed when r > 96), mostly narrow so the walk stays short.
    wl = $urandom_range(0, 100);
    xl = (r < 40) ? wl - $urandom_range(1, 300) : $urandom_range(0, 127);
    if (r < 28) xl = -$urandom_range(1, 32768);
    c = make_draw(xl, $urandom_range(0, 3) == 0 ? $urandom_range(0, 32767)
                                                : $urandom_range(0, 80),
                  xl + ((r < 30) ? $urandom_range(0, 32767) : $urandom_range(0, 40)),
                  $urandom_range(0, 3) == 0 ? $urandom_range(0, 32767) : $urandom_range(0, 80),
                  $urandom_range(0, 4) == 0 ? -1 : xl + $urandom_range(0, 20),
                  $urandom, $urandom_range(0, 3), $urandom_range(0, 3),
                  wl, $urandom_range(wl, 128 + (r % 2) * 127));
    if (r > 96) c.x_right = 16'(xl - $urandom_range(1, 50));
    if (c.x_right < xl && r <= 96) c.x_right = 16'sh7fff;
    return c;
  endfunction

  task automatic send(wcr_tb_pkg::span_cmd_t c);
    in_chan.cmd <= c.cmd; in_chan.x_left <= c.x_left; in_chan.h_left <= c.h_left;
    in_chan.x_right <= c.x_right; in_chan.h_right <= c.h_right;
    in_chan.x_middle <= c.x_middle; in_chan.wall_colour <= c.wall_colour;
    in_chan.left_edge <= c.left_edge; in_chan.right_edge <= c.right_edge;
    in_chan.window_left <= c.window_left; in_chan.window_right <= c.window_right;
    in_chan.read_column <= c.read_column;
    in_chan.valid <= 1'b1;
    do @(posedge clk); while (!in_chan.ready);
    if (c.cmd == wcr_pkg::CMD_DRAW) begin
      n_draw++;
      if (c.x_left < $signed({1'b0, c.window_left})) n_clip++;
    end else if (c.cmd == wcr_pkg::CMD_READ) n_read++;
    else n_clear++;
    @(negedge clk);
  endtask

  initial begin
    int i, burst, gap, waited;
    for (i = 0; i < 5; i++) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    stim.push_back(make_other(wcr_pkg::CMD_READ, 127));
    stim.push_back(make_draw(0, 10, 127, 70, 64, 8'hff, wcr_pkg::STYLE_BRICK,
                             wcr_pkg::STYLE_LINE, 0, 128));
    stim.push_back(make_draw(10, 32767, 20, 0, 15, 8'h00, wcr_pkg::STYLE_LINE,
                             wcr_pkg::STYLE_BRICK, 0, 128));
    stim.push_back(make_draw(-32768, 0, 32767, 32767, -1, 8'h5a, wcr_pkg::STYLE_BRICK,
                             wcr_pkg::STYLE_NONE, 0, 128));
    stim.push_back(make_draw(-10, 50, 30, 5, 0, 8'ha5, wcr_pkg::STYLE_LINE,
                             wcr_pkg::STYLE_LINE, 5, 100));
    stim.push_back(make_draw(40, 9, 39, 60, -1, 8'h11, wcr_pkg::STYLE_NONE,
                             wcr_pkg::STYLE_NONE, 0, 128));
    stim.push_back(make_draw(-50, 60, -20, 60, -1, 8'h22, wcr_pkg::STYLE_NONE,
                             wcr_pkg::STYLE_NONE, 0, 128));
    stim.push_back(make_draw(120, 60, 200, 63, 125, 8'h33, wcr_pkg::STYLE_SPARE,
                             wcr_pkg::STYLE_SPARE, 100, 255));
    stim.push_back(make_draw(77, 63, 77, 63, 77, 8'h44, wcr_pkg::STYLE_BRICK,
                             wcr_pkg::STYLE_LINE, 0, 128));
    stim.push_back(make_draw(64, 20, 80, 40, 70, 8'h55, wcr_pkg::STYLE_NONE,
                             wcr_pkg::STYLE_NONE, 128, 128));
    stim.push_back(make_draw(0, 5, 0, 5, 0, 8'h66, wcr_pkg::STYLE_NONE,
                             wcr_pkg::STYLE_NONE, 0, 0));
    stim.push_back(make_other(wcr_pkg::CMD_READ, 0));
    stim.push_back(make_other(wcr_pkg::CMD_READ, 64));
    stim.push_back(make_other(wcr_pkg::CMD_READ, 77));
    stim.push_back(make_other(wcr_pkg::CMD_SPARE, 0));
    stim.push_back(make_other(wcr_pkg::CMD_CLEAR, 0));
    stim.push_back(make_other(wcr_pkg::CMD_READ, 64));
    stim.push_back(make_draw(3, 1, 9, 2, 5, 8'h80, wcr_pkg::STYLE_NONE,
                             wcr_pkg::STYLE_LINE, 0, 8));
    for (i = 0; i < 1800; i++) stim.push_back(random_command());

    while (stim.size() > 0) begin
      burst = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
      while (burst > 0 && stim.size() > 0) begin
        send(stim.pop_front());
        burst--;
      end
      in_chan.valid <= 1'b0;
      gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
      repeat (gap) @(negedge clk);
    end
    in_chan.valid <= 1'b0;

    waited = 0;
    while (board.pending.size() > 0 && waited < 100000) begin
      @(negedge clk);
      waited++;
    end
    repeat (200) @(negedge clk);
    $display("covered %0d draws (%0d clipped), %0d reads, %0d clears/others",
             n_draw, n_clip, n_read, n_clear);
    if (board.pending.size() > 0) report("results still outstanding", board.pending.size(), 0);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
